@@ rtl/gdh_pkg.sv @@
// ----------------------------------------------------------------------------
// gdh_pkg
// Shared types and constants for the GPIB device handshake block.
// ----------------------------------------------------------------------------
package gdh_pkg;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_CMD_DAV    = 4'd1,
        PH_CMD_REPLY  = 4'd2,
        PH_CMD_DAVHI  = 4'd3,
        PH_LSN_DAV    = 4'd4,
        PH_LSN_DAVHI  = 4'd5,
        PH_TLK_NDAC   = 4'd6,
        PH_TLK_NRFDHI = 4'd7,
        PH_TLK_FETCH  = 4'd8,
        PH_TLK_NRFDLO = 4'd9,
        PH_TLK_NDACHI = 4'd10,
        PH_TLK_COMMIT = 4'd11,
        PH_TLK_NDACLO = 4'd12
    } phase_t;

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_COMMAND   = 3'd1,
        EV_LISTEN    = 3'd2,
        EV_TALK_TAKEN = 3'd3,
        EV_NO_DEVICE = 3'd4,
        EV_ATN_ABORT = 3'd5,
        EV_TALK_END  = 3'd6
    } ev_t;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_LISTEN  = 2'd1,
        MODE_TALK    = 2'd2,
        MODE_TALK_TO = 2'd3
    } mode_t;

    // Input kind codes as they arrive on the port.
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_REPLY = 2'd1;
    localparam logic [1:0] KIND_TX    = 2'd2;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_REPLY = 2'd1,
        OP_TX    = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef struct packed {
        op_t         op;
        logic        atn_low;
        logic        dav_low;
        logic        nrfd_low;
        logic        ndac_low;
        logic        eoi_low;
        logic [7:0]  bus_data;
        mode_t       reply_mode;
        logic [7:0]  tx_byte;
        logic        tx_last;
        logic        tx_timeout;
        logic        tx_stop;
    } cmd_t;

endpackage

@@ rtl/gdh_front.sv @@
// ----------------------------------------------------------------------------
// gdh_front
// Accepts input beats, decodes the item kind and pushes a command entry.
// ----------------------------------------------------------------------------
module gdh_front
(
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        kind,
    input  logic              atn_low,
    input  logic              dav_low,
    input  logic              nrfd_low,
    input  logic              ndac_low,
    input  logic              eoi_low,
    input  logic [7:0]        bus_data,
    input  logic [1:0]        reply_mode,
    input  logic [7:0]        tx_byte,
    input  logic              tx_last,
    input  logic              tx_timeout,
    input  logic              tx_stop,
    input  logic              q_full,
    output logic              q_push,
    output gdh_pkg::cmd_t     q_cmd
);

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_cmd.atn_low    = atn_low;
        q_cmd.dav_low    = dav_low;
        q_cmd.nrfd_low   = nrfd_low;
        q_cmd.ndac_low   = ndac_low;
        q_cmd.eoi_low    = eoi_low;
        q_cmd.bus_data   = bus_data;
        q_cmd.reply_mode = gdh_pkg::mode_t'(reply_mode);
        q_cmd.tx_byte    = tx_byte;
        q_cmd.tx_last    = tx_last;
        q_cmd.tx_timeout = tx_timeout;
        q_cmd.tx_stop    = tx_stop;
        case (kind)
            gdh_pkg::KIND_TICK:  q_cmd.op = gdh_pkg::OP_TICK;
            gdh_pkg::KIND_REPLY: q_cmd.op = gdh_pkg::OP_REPLY;
            gdh_pkg::KIND_TX:    q_cmd.op = gdh_pkg::OP_TX;
            default:             q_cmd.op = gdh_pkg::OP_NONE;
        endcase
    end

endmodule

@@ rtl/gdh_queue.sv @@
// ----------------------------------------------------------------------------
// gdh_queue
// Small command FIFO between the decode front and the handshake engine.
// ----------------------------------------------------------------------------
module gdh_queue
#(
    parameter int DEPTH = gdh_pkg::QUEUE_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  gdh_pkg::cmd_t     push_cmd,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output gdh_pkg::cmd_t     head_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    gdh_pkg::cmd_t     entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    property p_no_overflow;
        @(posedge clk) disable iff (!rst_n)
        full |-> !push;
    endproperty
    a_no_overflow: assert property (p_no_overflow)
        else $error("queue written while full");

    property p_no_underflow;
        @(posedge clk) disable iff (!rst_n)
        pop |-> head_valid;
    endproperty
    a_no_underflow: assert property (p_no_underflow)
        else $error("queue read while empty");

    property p_count_bound;
        @(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT;
    endproperty
    a_count_bound: assert property (p_count_bound)
        else $error("queue count out of range");

endmodule

@@ rtl/gdh_back.sv @@
// ----------------------------------------------------------------------------
// gdh_back
// Handshake engine: steps the phase machine per command and holds the result.
// ----------------------------------------------------------------------------
module gdh_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  gdh_pkg::cmd_t     q_cmd,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              drive_nrfd_low,
    output logic              drive_ndac_low,
    output logic              drive_dav_low,
    output logic              drive_eoi_low,
    output logic              drive_atna_low,
    output logic              drive_data_enable,
    output logic [7:0]        data_out,
    output logic [2:0]        event_res,
    output logic [7:0]        event_byte,
    output logic              event_eoi,
    output logic [3:0]        phase
);

    gdh_pkg::phase_t phase_reg;
    gdh_pkg::phase_t phase_next;
    logic            bus_active_reg;
    logic            bus_active_next;
    gdh_pkg::mode_t  mode_reg;
    gdh_pkg::mode_t  mode_next;
    logic [7:0]      tx_hold_reg;
    logic [7:0]      tx_hold_next;
    logic            tx_eof_reg;
    logic            tx_eof_next;

    gdh_pkg::ev_t    ev;
    logic [7:0]      ev_byte;
    logic            ev_eoi;
    logic            nrfd_o;
    logic            ndac_o;
    logic            dav_o;
    logic            eoi_o;
    logic            atna_o;
    logic            den_o;

    logic            out_valid_reg;
    logic            nrfd_reg;
    logic            ndac_reg;
    logic            dav_reg;
    logic            eoi_reg;
    logic            atna_reg;
    logic            den_reg;
    logic [7:0]      data_reg;
    gdh_pkg::ev_t    ev_reg;
    logic [7:0]      ev_byte_reg;
    logic            ev_eoi_reg;
    logic [3:0]      phase_out_reg;

    // A command is taken whenever the result register is empty or drains now.
    assign q_pop = q_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        phase_next      = phase_reg;
        bus_active_next = bus_active_reg;
        mode_next       = mode_reg;
        tx_hold_next    = tx_hold_reg;
        tx_eof_next     = tx_eof_reg;
        ev              = gdh_pkg::EV_NONE;
        ev_byte         = '0;
        ev_eoi          = 1'b0;

        case (q_cmd.op)
            gdh_pkg::OP_TICK:
            begin
                case (phase_reg)
                    gdh_pkg::PH_IDLE:
                    begin
                        if (!q_cmd.atn_low)
                        begin
                            bus_active_next = 1'b1;
                        end
                        else if (bus_active_reg)
                        begin
                            mode_next  = gdh_pkg::MODE_IDLE;
                            phase_next = gdh_pkg::PH_CMD_DAV;
                        end
                    end
                    gdh_pkg::PH_CMD_DAV:
                    begin
                        if (!q_cmd.atn_low)
                        begin
                            case (mode_reg)
                                gdh_pkg::MODE_LISTEN:
                                begin
                                    phase_next = gdh_pkg::PH_LSN_DAV;
                                end
                                gdh_pkg::MODE_TALK:
                                begin
                                    tx_eof_next = 1'b0;
                                    phase_next  = gdh_pkg::PH_TLK_NDAC;
                                end
                                default:
                                begin
                                    tx_eof_next = 1'b0;
                                    phase_next  = gdh_pkg::PH_IDLE;
                                end
                            endcase
                        end
                        else if (q_cmd.dav_low)
                        begin
                            ev         = gdh_pkg::EV_COMMAND;
                            ev_byte    = q_cmd.bus_data;
                            phase_next = gdh_pkg::PH_CMD_REPLY;
                        end
                    end
                    gdh_pkg::PH_CMD_DAVHI:
                    begin
                        if (!q_cmd.dav_low)
                        begin
                            phase_next = gdh_pkg::PH_CMD_DAV;
                        end
                    end
                    gdh_pkg::PH_LSN_DAV:
                    begin
                        if (q_cmd.atn_low)
                        begin
                            ev          = gdh_pkg::EV_ATN_ABORT;
                            tx_eof_next = 1'b0;
                            phase_next  = gdh_pkg::PH_IDLE;
                        end
                        else if (q_cmd.dav_low)
                        begin
                            ev         = gdh_pkg::EV_LISTEN;
                            ev_byte    = q_cmd.bus_data;
                            ev_eoi     = q_cmd.eoi_low;
                            phase_next = gdh_pkg::PH_LSN_DAVHI;
                        end
                    end
                    gdh_pkg::PH_LSN_DAVHI:
                    begin
                        if (!q_cmd.dav_low)
                        begin
                            phase_next = gdh_pkg::PH_LSN_DAV;
                        end
                    end
                    gdh_pkg::PH_TLK_NDAC:
                    begin
                        if (q_cmd.ndac_low || q_cmd.atn_low)
                        begin
                            phase_next = gdh_pkg::PH_TLK_NRFDHI;
                        end
                    end
                    gdh_pkg::PH_TLK_NRFDHI:
                    begin
                        if (q_cmd.atn_low)
                        begin
                            ev          = gdh_pkg::EV_ATN_ABORT;
                            tx_eof_next = 1'b0;
                            phase_next  = gdh_pkg::PH_IDLE;
                        end
                        else if (!q_cmd.nrfd_low)
                        begin
                            phase_next = gdh_pkg::PH_TLK_FETCH;
                        end
                    end
                    gdh_pkg::PH_TLK_NRFDLO:
                    begin
                        if (q_cmd.atn_low)
                        begin
                            ev          = gdh_pkg::EV_ATN_ABORT;
                            tx_eof_next = 1'b0;
                            phase_next  = gdh_pkg::PH_IDLE;
                        end
                        else if (!q_cmd.ndac_low && !q_cmd.nrfd_low)
                        begin
                            // Both lines released: nobody is listening.
                            ev          = gdh_pkg::EV_NO_DEVICE;
                            tx_eof_next = 1'b0;
                            phase_next  = gdh_pkg::PH_IDLE;
                        end
                        else if (q_cmd.nrfd_low)
                        begin
                            phase_next = gdh_pkg::PH_TLK_NDACHI;
                        end
                    end
                    gdh_pkg::PH_TLK_NDACHI:
                    begin
                        if (q_cmd.atn_low)
                        begin
                            ev          = gdh_pkg::EV_ATN_ABORT;
                            tx_eof_next = 1'b0;
                            phase_next  = gdh_pkg::PH_IDLE;
                        end
                        else if (!q_cmd.ndac_low)
                        begin
                            ev         = gdh_pkg::EV_TALK_TAKEN;
                            phase_next = gdh_pkg::PH_TLK_COMMIT;
                        end
                    end
                    gdh_pkg::PH_TLK_NDACLO:
                    begin
                        if (q_cmd.atn_low)
                        begin
                            ev          = gdh_pkg::EV_ATN_ABORT;
                            tx_eof_next = 1'b0;
                            phase_next  = gdh_pkg::PH_IDLE;
                        end
                        else if (q_cmd.ndac_low)
                        begin
                            if (tx_eof_reg)
                            begin
                                ev          = gdh_pkg::EV_TALK_END;
                                tx_eof_next = 1'b0;
                                phase_next  = gdh_pkg::PH_IDLE;
                            end
                            else
                            begin
                                phase_next = gdh_pkg::PH_TLK_NRFDHI;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            gdh_pkg::OP_REPLY:
            begin
                if (phase_reg == gdh_pkg::PH_CMD_REPLY)
                begin
                    mode_next  = q_cmd.reply_mode;
                    phase_next = gdh_pkg::PH_CMD_DAVHI;
                end
            end
            gdh_pkg::OP_TX:
            begin
                if (phase_reg == gdh_pkg::PH_TLK_FETCH)
                begin
                    if (q_cmd.tx_timeout)
                    begin
                        ev          = gdh_pkg::EV_TALK_END;
                        tx_eof_next = 1'b0;
                        phase_next  = gdh_pkg::PH_IDLE;
                    end
                    else
                    begin
                        tx_hold_next = q_cmd.tx_byte;
                        tx_eof_next  = q_cmd.tx_last;
                        phase_next   = gdh_pkg::PH_TLK_NRFDLO;
                    end
                end
                else if (phase_reg == gdh_pkg::PH_TLK_COMMIT)
                begin
                    if (q_cmd.tx_stop)
                    begin
                        ev          = gdh_pkg::EV_TALK_END;
                        tx_eof_next = 1'b0;
                        phase_next  = gdh_pkg::PH_IDLE;
                    end
                    else
                    begin
                        phase_next = gdh_pkg::PH_TLK_NDACLO;
                    end
                end
            end
            default:
            begin
            end
        endcase

        // Line drives follow the phase the step lands in.
        nrfd_o = 1'b0;
        ndac_o = 1'b0;
        dav_o  = 1'b0;
        eoi_o  = 1'b0;
        atna_o = 1'b0;
        den_o  = 1'b0;
        case (phase_next)
            gdh_pkg::PH_CMD_DAV:
            begin
                atna_o = 1'b1;
                ndac_o = 1'b1;
            end
            gdh_pkg::PH_CMD_REPLY,
            gdh_pkg::PH_CMD_DAVHI:
            begin
                atna_o = 1'b1;
                nrfd_o = 1'b1;
            end
            gdh_pkg::PH_LSN_DAV:
            begin
                ndac_o = 1'b1;
            end
            gdh_pkg::PH_LSN_DAVHI:
            begin
                nrfd_o = 1'b1;
            end
            gdh_pkg::PH_TLK_NRFDLO,
            gdh_pkg::PH_TLK_NDACHI:
            begin
                den_o = 1'b1;
                dav_o = 1'b1;
                eoi_o = tx_eof_next;
            end
            gdh_pkg::PH_TLK_NDAC,
            gdh_pkg::PH_TLK_NRFDHI,
            gdh_pkg::PH_TLK_FETCH,
            gdh_pkg::PH_TLK_COMMIT,
            gdh_pkg::PH_TLK_NDACLO:
            begin
                den_o = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= gdh_pkg::PH_IDLE;
            bus_active_reg <= 1'b0;
            mode_reg       <= gdh_pkg::MODE_IDLE;
            tx_hold_reg    <= '0;
            tx_eof_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                phase_reg      <= phase_next;
                bus_active_reg <= bus_active_next;
                mode_reg       <= mode_next;
                tx_hold_reg    <= tx_hold_next;
                tx_eof_reg     <= tx_eof_next;
                out_valid_reg  <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            nrfd_reg      <= nrfd_o;
            ndac_reg      <= ndac_o;
            dav_reg       <= dav_o;
            eoi_reg       <= eoi_o;
            atna_reg      <= atna_o;
            den_reg       <= den_o;
            data_reg      <= den_o ? tx_hold_next : 8'd0;
            ev_reg        <= ev;
            ev_byte_reg   <= ev_byte;
            ev_eoi_reg    <= ev_eoi;
            phase_out_reg <= phase_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign drive_nrfd_low    = nrfd_reg;
    assign drive_ndac_low    = ndac_reg;
    assign drive_dav_low     = dav_reg;
    assign drive_eoi_low     = eoi_reg;
    assign drive_atna_low    = atna_reg;
    assign drive_data_enable = den_reg;
    assign data_out          = data_reg;
    assign event_res         = ev_reg;
    assign event_byte        = ev_byte_reg;
    assign event_eoi         = ev_eoi_reg;
    assign phase             = phase_out_reg;

    // Once ATN has been seen high the bus stays live until reset.
    property p_bus_active_sticky;
        @(posedge clk) disable iff (!rst_n)
        bus_active_reg |=> bus_active_reg;
    endproperty
    a_bus_active_sticky: assert property (p_bus_active_sticky)
        else $error("bus_active cleared after being set");

    // The reported phase always matches the engine state it came from.
    property p_phase_tracks;
        @(posedge clk) disable iff (!rst_n)
        q_pop |=> (phase_out_reg == phase_reg);
    endproperty
    a_phase_tracks: assert property (p_phase_tracks)
        else $error("reported phase differs from engine phase");

    // A talker never pulls the listener lines.
    property p_talk_lines;
        @(posedge clk) disable iff (!rst_n)
        (out_valid_reg && den_reg) |-> (!nrfd_reg && !ndac_reg && !atna_reg);
    endproperty
    a_talk_lines: assert property (p_talk_lines)
        else $error("listener line driven while talking");

    // EOI flag on a result belongs to a listen beat only.
    property p_eoi_event;
        @(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ev_eoi_reg) |-> (ev_reg == gdh_pkg::EV_LISTEN);
    endproperty
    a_eoi_event: assert property (p_eoi_event)
        else $error("event_eoi set on a non-listen event");

endmodule

@@ rtl/gpib_device_handshake_top.sv @@
// ----------------------------------------------------------------------------
// gpib_device_handshake_top
// Device side of the GPIB three-wire handshake with ATN and EOI handling.
// ----------------------------------------------------------------------------
// Throughput: one item per clock while out_stall is low and the queue has room;
// the phase engine steps once per popped command. A beat is first written into
// the command queue, then steps the engine and loads the result register.
// Reset (rst_n low, asynchronous): idle phase, bus inactive, mode idle,
// held talk byte zero, queue and result register empty.
module gpib_device_handshake_top
#(
    parameter int QUEUE_DEPTH = gdh_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic        atn_low,
    input  logic        dav_low,
    input  logic        nrfd_low,
    input  logic        ndac_low,
    input  logic        eoi_low,
    input  logic [7:0]  bus_data,
    input  logic [1:0]  reply_mode,
    input  logic [7:0]  tx_byte,
    input  logic        tx_last,
    input  logic        tx_timeout,
    input  logic        tx_stop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        drive_nrfd_low,
    output logic        drive_ndac_low,
    output logic        drive_dav_low,
    output logic        drive_eoi_low,
    output logic        drive_atna_low,
    output logic        drive_data_enable,
    output logic [7:0]  data_out,
    output logic [2:0]  event_res,
    output logic [7:0]  event_byte,
    output logic        event_eoi,
    output logic [3:0]  phase
);

    logic           q_full;
    logic           q_push;
    gdh_pkg::cmd_t  q_push_cmd;
    logic           q_pop;
    logic           q_valid;
    gdh_pkg::cmd_t  q_head_cmd;

    gdh_front u_front
    (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .atn_low    (atn_low),
        .dav_low    (dav_low),
        .nrfd_low   (nrfd_low),
        .ndac_low   (ndac_low),
        .eoi_low    (eoi_low),
        .bus_data   (bus_data),
        .reply_mode (reply_mode),
        .tx_byte    (tx_byte),
        .tx_last    (tx_last),
        .tx_timeout (tx_timeout),
        .tx_stop    (tx_stop),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_cmd      (q_push_cmd)
    );

    gdh_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (q_head_cmd)
    );

    gdh_back u_back
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .q_valid           (q_valid),
        .q_cmd             (q_head_cmd),
        .q_pop             (q_pop),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .drive_nrfd_low    (drive_nrfd_low),
        .drive_ndac_low    (drive_ndac_low),
        .drive_dav_low     (drive_dav_low),
        .drive_eoi_low     (drive_eoi_low),
        .drive_atna_low    (drive_atna_low),
        .drive_data_enable (drive_data_enable),
        .data_out          (data_out),
        .event_res         (event_res),
        .event_byte        (event_byte),
        .event_eoi         (event_eoi),
        .phase             (phase)
    );

endmodule
